// ----- src/dfs7_pkg.sv -----
`default_nettype none

package dfs7_pkg;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_X      = 2'd0,
      CSR_GRID_Y      = 2'd1,
      CSR_GRID_Z      = 2'd2,
      CSR_UPDATE_GAIN = 2'd3
   } csr_index_type;

   // Register widths and reset values
   localparam int GRID_XY_BITS = 7;
   localparam int PLANE_BITS   = 16;
   localparam int GAIN_BITS    = 16;
   localparam int GRID_MIN     = 3;
   localparam int GRID_X_RST   = 64;
   localparam int GRID_Y_RST   = 64;
   localparam int GRID_Z_RST   = 64;
   localparam logic [GAIN_BITS-1:0] GAIN_RST = 16'd10923;

   // Update arithmetic: Q0.16 gain, intermediates wrap at 64 bits
   localparam int FRAC_BITS = 16;
   localparam int WRAP_BITS = 64;
   localparam logic [WRAP_BITS-1:0] ROUND_HALF = 64'h8000;

   // Control travelling alongside the stencil taps
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

`default_nettype wire

// ----- src/dfs7_delay_cell.sv -----
`default_nettype none

module dfs7_delay_cell #(
   parameter int ADDR_BITS = 6,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  logic [ADDR_BITS-1:0] rd_offset,
   input  logic [DATA_BITS-1:0] din,
   output logic [DATA_BITS-1:0] dout
);
   import dfs7_pkg::*;

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [ADDR_BITS-1:0] wr_ptr_ff;
   logic [ADDR_BITS-1:0] wr_ptr_in;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [DATA_BITS-1:0] dout_ff;

   // Circular buffer: delay of rd_offset+1 shifts, counting the read register
   assign wr_ptr_in = wr_ptr_ff + 1'b1;
   assign rd_addr   = wr_ptr_ff - rd_offset;
   assign dout      = dout_ff;

   // Advance the write pointer on every shift
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
      end else if (shift_en) begin
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // Write the new sample, read the one leaving the window
   always_ff @(posedge clock) begin
      if (shift_en) begin
         mem[wr_ptr_ff] <= din;
         dout_ff        <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/dfs7_update.sv -----
`default_nettype none

module dfs7_update #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  dfs7_pkg::ctl_type                    tap_ctl,
   input  logic [dfs7_pkg::GAIN_BITS-1:0]       gain,
   input  logic signed [SAMPLE_BITS-1:0]        tap_c,
   input  logic signed [SAMPLE_BITS-1:0]        tap_xm,
   input  logic signed [SAMPLE_BITS-1:0]        tap_xp,
   input  logic signed [SAMPLE_BITS-1:0]        tap_ym,
   input  logic signed [SAMPLE_BITS-1:0]        tap_yp,
   input  logic signed [SAMPLE_BITS-1:0]        tap_zm,
   input  logic signed [SAMPLE_BITS-1:0]        tap_zp,
   output logic                                 out_valid,
   output logic                                 out_last,
   output logic signed [SAMPLE_BITS-1:0]        out_value
);
   import dfs7_pkg::*;

   localparam int LAP_BITS = (SAMPLE_BITS + 4 > WRAP_BITS) ? WRAP_BITS : SAMPLE_BITS + 4;
   localparam int LO_BITS  = LAP_BITS / 2;
   localparam int HI_BITS  = LAP_BITS - LO_BITS;
   localparam int PLO_BITS = LO_BITS + GAIN_BITS;
   localparam int PHI_BITS = HI_BITS + GAIN_BITS + 1;

   // Stage control
   ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, out_ctl_ff;

   // Stage payload
   logic signed [LAP_BITS-1:0]    c_ext;
   logic signed [LAP_BITS-1:0]    sum_a_in, sum_b_in, c6_in;
   logic signed [LAP_BITS-1:0]    s1_sum_a_ff, s1_sum_b_ff, s1_c6_ff;
   logic signed [SAMPLE_BITS-1:0] s1_c_ff;
   logic signed [LAP_BITS-1:0]    lap_in, s2_lap_ff;
   logic signed [SAMPLE_BITS-1:0] s2_c_ff;
   logic [PLO_BITS-1:0]           prod_lo_in, s3_prod_lo_ff;
   logic signed [PHI_BITS-1:0]    prod_hi_in, s3_prod_hi_ff;
   logic signed [SAMPLE_BITS-1:0] s3_c_ff;
   logic signed [WRAP_BITS-1:0]   hi_ext, acc;
   logic signed [SAMPLE_BITS-1:0] inc_in, s4_inc_ff, s4_c_ff;
   logic signed [SAMPLE_BITS-1:0] value_in, out_value_ff;

   // Partial sums of the neighbours and six times the centre
   always_comb begin
      c_ext    = LAP_BITS'(tap_c);
      sum_a_in = LAP_BITS'(tap_xm) + LAP_BITS'(tap_xp) + LAP_BITS'(tap_ym);
      sum_b_in = LAP_BITS'(tap_yp) + LAP_BITS'(tap_zm) + LAP_BITS'(tap_zp);
      c6_in    = (c_ext <<< 2) + (c_ext <<< 1);
   end

   // Laplacian
   assign lap_in = s1_sum_a_ff + s1_sum_b_ff - s1_c6_ff;

   // Gain product split into two partial products
   assign prod_lo_in = PLO_BITS'(s2_lap_ff[LO_BITS-1:0]) * PLO_BITS'(gain);
   assign prod_hi_in = PHI_BITS'($signed(s2_lap_ff[LAP_BITS-1:LO_BITS]))
                       * PHI_BITS'($signed({1'b0, gain}));

   // Combine partial products, round half up, drop the fraction
   always_comb begin
      hi_ext = WRAP_BITS'(s3_prod_hi_ff);
      acc    = (hi_ext <<< LO_BITS) + WRAP_BITS'(s3_prod_lo_ff) + ROUND_HALF;
      inc_in = SAMPLE_BITS'(acc >>> FRAC_BITS);
   end

   // Final update, wraps at the sample width
   assign value_in = s4_c_ff + s4_inc_ff;

   // Control through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff  <= '0;
         s2_ctl_ff  <= '0;
         s3_ctl_ff  <= '0;
         s4_ctl_ff  <= '0;
         out_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff  <= tap_ctl;
         s2_ctl_ff  <= s1_ctl_ff;
         s3_ctl_ff  <= s2_ctl_ff;
         s4_ctl_ff  <= s3_ctl_ff;
         out_ctl_ff <= s4_ctl_ff;
      end
   end

   // Payload through the pipeline
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sum_a_ff   <= sum_a_in;
         s1_sum_b_ff   <= sum_b_in;
         s1_c6_ff      <= c6_in;
         s1_c_ff       <= tap_c;
         s2_lap_ff     <= lap_in;
         s2_c_ff       <= s1_c_ff;
         s3_prod_lo_ff <= prod_lo_in;
         s3_prod_hi_ff <= prod_hi_in;
         s3_c_ff       <= s2_c_ff;
         s4_inc_ff     <= inc_in;
         s4_c_ff       <= s3_c_ff;
         out_value_ff  <= value_in;
      end
   end

   assign out_valid = out_ctl_ff.valid;
   assign out_last  = out_ctl_ff.last;
   assign out_value = out_value_ff;

endmodule

`default_nettype wire

// ----- src/diffusion_7point_stencil.sv -----
// The result for point (x, y, z) leaves the update pipeline after the sample at
// (x, y, z+1) is accepted, one plane plus the pipeline behind its centre sample.
// Throughput: one sample per cycle unless a result waits on rsp_ready; each plane and
// row buffer does one write and read per transaction; the pipeline takes one a cycle.
// Reset: sizes 64 x 64 x 64, gain 10923, positions zero; buffers are not cleared,
// so req_ready is high once reset is released.
`default_nettype none

module diffusion_7point_stencil #(
   parameter int MAX_X       = 64,
   parameter int MAX_Y       = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]          rsp_new_value,
   output logic                                   rsp_last_point,
   input  logic                                   csr_wr_en,
   input  logic [dfs7_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dfs7_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);
   import dfs7_pkg::*;

   localparam int XW   = $clog2(MAX_X);
   localparam int YW   = $clog2(MAX_Y);
   localparam int XCW  = $clog2(MAX_X + 1);
   localparam int YCW  = $clog2(MAX_Y + 1);
   localparam int ROW_ADDR_BITS   = $clog2(MAX_X - 1);
   localparam int PLANE_ADDR_BITS = $clog2(MAX_X * (MAX_Y - 1));
   localparam int NX_RST = (MAX_X < GRID_X_RST) ? MAX_X : GRID_X_RST;
   localparam int NY_RST = (MAX_Y < GRID_Y_RST) ? MAX_Y : GRID_Y_RST;

   // Effective sizes and gain
   logic [XCW-1:0]        nx_ff, nx_wr;
   logic [YCW-1:0]        ny_ff, ny_wr;
   logic [PLANE_BITS-1:0] nz_ff, nz_wr;
   logic [GAIN_BITS-1:0]  gain_ff;

   // Raster position
   logic [XW-1:0]         col_ff, col_in;
   logic [YW-1:0]         row_ff, row_in;
   logic [PLANE_BITS-1:0] plane_ff, plane_in;
   logic                  col_wrap, row_wrap, plane_wrap;
   logic                  interior, last_pt;

   // Buffer offsets derived from the sizes
   logic [XCW+YCW-1:0]         plane_len;
   logic [PLANE_ADDR_BITS-1:0] plane_off_ff;
   logic [ROW_ADDR_BITS-1:0]   row_off;

   // Taps
   logic req_accept, advance;
   logic [SAMPLE_BITS-1:0] tap_yp, tap_xp, tap_ym, tap_zm;
   logic [SAMPLE_BITS-1:0] c_ff, xm_ff;
   ctl_type tap_ctl;

   // Advance the update pipeline and take requests when the output register is free or being taken
   assign advance    = !rsp_valid || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && req_ready;

   // Clamp written sizes into the supported range
   always_comb begin
      if (csr_wr_data[GRID_XY_BITS-1:0] < GRID_XY_BITS'(GRID_MIN)) begin
         nx_wr = XCW'(GRID_MIN);
      end else if (int'(csr_wr_data[GRID_XY_BITS-1:0]) > MAX_X) begin
         nx_wr = XCW'(MAX_X);
      end else begin
         nx_wr = XCW'(csr_wr_data[GRID_XY_BITS-1:0]);
      end
      if (csr_wr_data[GRID_XY_BITS-1:0] < GRID_XY_BITS'(GRID_MIN)) begin
         ny_wr = YCW'(GRID_MIN);
      end else if (int'(csr_wr_data[GRID_XY_BITS-1:0]) > MAX_Y) begin
         ny_wr = YCW'(MAX_Y);
      end else begin
         ny_wr = YCW'(csr_wr_data[GRID_XY_BITS-1:0]);
      end
      if (csr_wr_data[PLANE_BITS-1:0] < PLANE_BITS'(GRID_MIN)) begin
         nz_wr = PLANE_BITS'(GRID_MIN);
      end else begin
         nz_wr = csr_wr_data[PLANE_BITS-1:0];
      end
   end

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff   <= XCW'(NX_RST);
         ny_ff   <= YCW'(NY_RST);
         nz_ff   <= PLANE_BITS'(GRID_Z_RST);
         gain_ff <= GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_X:      nx_ff   <= nx_wr;
            CSR_GRID_Y:      ny_ff   <= ny_wr;
            CSR_GRID_Z:      nz_ff   <= nz_wr;
            CSR_UPDATE_GAIN: gain_ff <= csr_wr_data[GAIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Position decode
   always_comb begin
      col_wrap   = (XCW'(col_ff) == nx_ff - XCW'(1));
      row_wrap   = (YCW'(row_ff) == ny_ff - YCW'(1));
      plane_wrap = (plane_ff == nz_ff - PLANE_BITS'(1));
      interior   = (plane_ff >= PLANE_BITS'(2))
                   && (col_ff != '0)
                   && ((XCW+1)'(col_ff) + (XCW+1)'(2) <= (XCW+1)'(nx_ff))
                   && (row_ff != '0)
                   && ((YCW+1)'(row_ff) + (YCW+1)'(2) <= (YCW+1)'(ny_ff));
      last_pt    = ((XCW+1)'(col_ff) + (XCW+1)'(2) == (XCW+1)'(nx_ff))
                   && ((YCW+1)'(row_ff) + (YCW+1)'(2) == (YCW+1)'(ny_ff))
                   && plane_wrap;
   end

   // Step the raster position; any register write restarts the frame
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      plane_in = plane_ff;
      if (csr_wr_en) begin
         col_in   = '0;
         row_in   = '0;
         plane_in = '0;
      end else if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               row_in = '0;
               if (plane_wrap) begin
                  plane_in = '0;
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         plane_ff <= plane_in;
      end
   end

   // Buffer offsets: plane gap (ny-1)*nx, row gap nx-1, one less for the read register
   assign plane_len = (XCW+YCW)'(ny_ff - YCW'(1)) * (XCW+YCW)'(nx_ff);
   assign row_off   = ROW_ADDR_BITS'(nx_ff - XCW'(2));

   always_ff @(posedge clock) begin
      plane_off_ff <= PLANE_ADDR_BITS'(plane_len - (XCW+YCW)'(1));
   end

   // Chain of buffers: newest sample to the plane two behind
   dfs7_delay_cell #(
      .ADDR_BITS (PLANE_ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_plane_fwd (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .rd_offset (plane_off_ff),
      .din       (req_sample),
      .dout      (tap_yp)
   );

   dfs7_delay_cell #(
      .ADDR_BITS (ROW_ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_row_fwd (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .rd_offset (row_off),
      .din       (tap_yp),
      .dout      (tap_xp)
   );

   // Centre and left neighbour
   always_ff @(posedge clock) begin
      if (req_accept) begin
         c_ff  <= tap_xp;
         xm_ff <= c_ff;
      end
   end

   dfs7_delay_cell #(
      .ADDR_BITS (ROW_ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_row_back (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .rd_offset (row_off),
      .din       (xm_ff),
      .dout      (tap_ym)
   );

   dfs7_delay_cell #(
      .ADDR_BITS (PLANE_ADDR_BITS),
      .DATA_BITS (SAMPLE_BITS)
   ) u_plane_back (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (req_accept),
      .rd_offset (plane_off_ff),
      .din       (tap_ym),
      .dout      (tap_zm)
   );

   // Flag the transaction that completes an interior point
   always_comb begin
      tap_ctl.valid = req_accept && interior;
      tap_ctl.last  = last_pt;
   end

   dfs7_update #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tap_ctl   (tap_ctl),
      .gain      (gain_ff),
      .tap_c     ($signed(c_ff)),
      .tap_xm    ($signed(xm_ff)),
      .tap_xp    ($signed(tap_xp)),
      .tap_ym    ($signed(tap_ym)),
      .tap_yp    ($signed(tap_yp)),
      .tap_zm    ($signed(tap_zm)),
      .tap_zp    (req_sample),
      .out_valid (rsp_valid),
      .out_last  (rsp_last_point),
      .out_value (rsp_new_value)
   );

   // Checks
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (col_ff == '0) && (row_ff == '0) && (plane_ff == '0))
      else $error("frame not restarted after register write");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      XCW'(col_ff) < nx_ff)
      else $error("column position beyond row length");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      YCW'(row_ff) < ny_ff)
      else $error("row position beyond plane height");

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      plane_ff < nz_ff)
      else $error("plane position beyond grid depth");

endmodule

`default_nettype wire
